>>> rtl/rnft_pkg.sv
// Shared types and constants for the RSSI noise floor tracker.
// Holds request codes, register indexes, the controller state type and the
// control bundle that the top level drives into every window cell.
package rnft_pkg;

    // Fixed field widths of the request and configuration interface.
    localparam int RSSI_W    = 8;
    localparam int TIME_W    = 32;
    localparam int WARMUP_W  = 8;
    localparam int RESTART_W = 16;

    // Control bundle widths cover the full parameter ranges: up to eight
    // channels and windows of up to 32 readings (count range 0 to 32).
    localparam int CH_IDX_W  = 3;
    localparam int CNT_IDX_W = 6;
    localparam int BIT_IDX_W = 3;

    localparam logic [RSSI_W-1:0]    UNKNOWN_FLOOR = 8'hFF;
    localparam logic [WARMUP_W-1:0]  WARMUP_RESET  = 8'd30;
    localparam logic [RESTART_W-1:0] RESTART_RESET = 16'd180;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_WARMUP  = 1'b0;
    localparam logic REG_RESTART = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SELECT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 shift;
        logic                 init;
        logic                 step;
        logic [CH_IDX_W-1:0]  ch;
        logic [CNT_IDX_W-1:0] n_valid;
        logic [BIT_IDX_W-1:0] bit_pos;
        logic                 keep_one;
    } cell_ctrl_t;

endpackage

>>> rtl/rnft_cell.sv
// One position of the reading window, holding that position for every channel.
// Depends on rnft_pkg for the control bundle and field widths.
module rnft_cell #(
    parameter int NUM_CHANNELS = 2,
    parameter int IDX          = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rnft_pkg::cell_ctrl_t            ctrl,
    input  logic [rnft_pkg::RSSI_W-1:0]     shift_in,
    input  logic [rnft_pkg::RSSI_W-1:0]     probe,
    output logic [rnft_pkg::RSSI_W-1:0]     value,
    output logic                            ge_probe,
    output logic                            vote,
    output logic                            cand
);
    import rnft_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [RSSI_W-1:0] val_reg [NUM_CHANNELS];
    logic              cand_reg;
    logic              cand_next;
    logic [CH_W-1:0]   ch_idx;

    assign ch_idx   = ctrl.ch[CH_W-1:0];
    assign value    = val_reg[ch_idx];
    assign ge_probe = (value >= probe);
    // A candidate whose current bit is zero counts toward the lower group.
    assign vote     = cand_reg & ~value[ctrl.bit_pos];
    assign cand     = cand_reg;

    always_comb
    begin
        priority if (ctrl.init)
        begin
            cand_next = (CNT_IDX_W'(IDX) < ctrl.n_valid);
        end
        else if (ctrl.step)
        begin
            cand_next = cand_reg & (value[ctrl.bit_pos] == ctrl.keep_one);
        end
        else
        begin
            cand_next = cand_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            val_reg[ch_idx] <= shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= 1'b0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

endmodule

>>> rtl/rssi_noise_floor_tracker_top.sv
// RSSI noise floor tracker: per-channel low-biased window with upper median.
// Depends on rnft_pkg and rnft_cell. Ticks, ignored samples, empty windows and
// warm-up answers go from the accepted beat straight to ST_DONE; median answers
// first pass through ST_SELECT (8 one-bit selection steps). ST_DONE loads the
// result into the output register once it is free; no new beat is taken until then.
// Reset clears time, counts and control; warmup 30 s, restart 180 s.
module rssi_noise_floor_tracker_top #(
    parameter int WINDOW_DEPTH = 10,
    parameter int NUM_CHANNELS = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Request channel.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        req_type,
    input  logic                              channel,
    input  logic [rnft_pkg::RSSI_W-1:0]       rssi,
    input  logic [rnft_pkg::TIME_W-1:0]       time_seconds,
    // Result channel.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rnft_pkg::RSSI_W-1:0]       noise_floor
);
    import rnft_pkg::*;

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access phase;
    // the port never inserts wait states.
    // ------------------------------------------------------------------
    logic [WARMUP_W-1:0]  warmup_reg;
    logic [RESTART_W-1:0] restart_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_WARMUP:  prdata = {{(32-WARMUP_W){1'b0}}, warmup_reg};
            REG_RESTART: prdata = {{(32-RESTART_W){1'b0}}, restart_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_reg  <= WARMUP_RESET;
            restart_reg <= RESTART_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_WARMUP)
            begin
                warmup_reg <= pwdata[WARMUP_W-1:0];
            end
            else
            begin
                restart_reg <= pwdata[RESTART_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Controller and tracking state.
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [TIME_W-1:0]    cur_time_reg, cur_time_next;
    logic [TIME_W-1:0]    start_time_reg, start_time_next;
    logic [CNT_W-1:0]     count_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]     count_next [NUM_CHANNELS];
    logic [CH_W-1:0]      ch_reg, ch_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [BIT_IDX_W-1:0] step_reg, step_next;
    logic [RSSI_W-1:0]    med_reg, med_next;
    logic [RSSI_W-1:0]    res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    logic [RSSI_W-1:0]    noise_floor_reg, noise_floor_next;

    // Row of window cells and the signals they return.
    cell_ctrl_t           cell_ctrl;
    logic [RSSI_W-1:0]    value_vec [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] ge_vec;
    logic [WINDOW_DEPTH-1:0] vote_vec;
    logic [WINDOW_DEPTH-1:0] cand_vec;
    logic [WINDOW_DEPTH-1:0] in_win;

    // Decode of the accepted beat.
    logic                 in_fire;
    logic                 out_free;
    logic                 ch_ok;
    logic [CH_W-1:0]      ch_sel;
    logic [CNT_W-1:0]     cnt_cur;
    logic [CNT_W-1:0]     n_clamp;
    logic [CNT_W-1:0]     n_new;
    logic                 fits;
    logic                 take;
    logic                 time_known;
    logic                 warm;
    logic [TIME_W-1:0]    elapsed_cur;
    logic [TIME_W-1:0]    start_eff;
    logic [TIME_W-1:0]    tick_elapsed;
    logic                 restart_hit;
    logic                 go_select;
    logic [CNT_W-1:0]     n_sel;
    logic                 do_shift;

    // Selection step.
    logic [CNT_W-1:0]     zeros;
    logic                 bit_one;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign out_free  = ~out_valid_reg | out_ready;
    assign out_valid = out_valid_reg;
    assign noise_floor = noise_floor_reg;

    // Samples and queries on unconfigured channels leave windows and counts alone.
    assign ch_ok   = ((CH_W+1)'(channel) < (CH_W+1)'(NUM_CHANNELS));
    assign ch_sel  = ch_ok ? CH_W'(channel) : '0;
    assign cnt_cur = count_reg[ch_sel];

    // A full window drops its oldest reading before the new one is judged.
    assign n_clamp = (cnt_cur >= CNT_W'(WINDOW_DEPTH)) ? CNT_W'(WINDOW_DEPTH - 1) : cnt_cur;

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_win
        assign in_win[i] = (CNT_W'(i) < n_clamp);
    end

    // The sample enters the window when it is no greater than some stored
    // reading, or when the window is empty.
    assign fits  = |(ge_vec & in_win);
    assign take  = (n_clamp == '0) | fits;
    assign n_new = take ? (n_clamp + CNT_W'(1)) : n_clamp;

    assign time_known  = (cur_time_reg != '0);
    assign elapsed_cur = cur_time_reg - start_time_reg;
    assign warm        = (elapsed_cur < {{(TIME_W-WARMUP_W){1'b0}}, warmup_reg});

    // The first tick while the time is unknown also sets the start time.
    assign start_eff    = time_known ? start_time_reg : time_seconds;
    assign tick_elapsed = time_seconds - start_eff;
    assign restart_hit  = (tick_elapsed > {{(TIME_W-RESTART_W){1'b0}}, restart_reg});

    // Work out whether the accepted beat needs a rank selection, and over
    // how many readings.
    always_comb
    begin
        go_select = 1'b0;
        n_sel     = '0;
        do_shift  = 1'b0;
        if (in_fire && ch_ok)
        begin
            if (req_type == REQ_SAMPLE && time_known)
            begin
                do_shift = take;
                if (n_clamp != '0 && !warm)
                begin
                    go_select = 1'b1;
                    n_sel     = n_new;
                end
            end
            else if (req_type == REQ_QUERY && cnt_cur != '0)
            begin
                go_select = 1'b1;
                n_sel     = cnt_cur;
            end
        end
    end

    // Count of remaining candidates whose current bit is zero.
    always_comb
    begin
        zeros = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            zeros = zeros + CNT_W'(vote_vec[i]);
        end
    end

    // If the wanted rank lies past the zero group, the answer bit is one.
    assign bit_one = ~(k_reg < zeros);

    always_comb
    begin
        cell_ctrl          = '0;
        cell_ctrl.shift    = do_shift;
        cell_ctrl.init     = go_select;
        cell_ctrl.step     = (state_reg == ST_SELECT);
        cell_ctrl.ch       = (state_reg == ST_IDLE) ? CH_IDX_W'(ch_sel) : CH_IDX_W'(ch_reg);
        cell_ctrl.n_valid  = CNT_IDX_W'(n_sel);
        cell_ctrl.bit_pos  = step_reg;
        cell_ctrl.keep_one = bit_one;
    end

    for (genvar g = 0; g < WINDOW_DEPTH; g++)
    begin : g_cell
        logic [RSSI_W-1:0] cell_in;
        if (g == 0)
        begin : g_head
            assign cell_in = rssi;
        end
        else
        begin : g_link
            assign cell_in = value_vec[g-1];
        end

        rnft_cell #(
            .NUM_CHANNELS (NUM_CHANNELS),
            .IDX          (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .shift_in (cell_in),
            .probe    (rssi),
            .value    (value_vec[g]),
            .ge_probe (ge_vec[g]),
            .vote     (vote_vec[g]),
            .cand     (cand_vec[g])
        );
    end

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = go_select ? ST_SELECT : ST_DONE;
                end
            end
            ST_SELECT:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs.
    // ------------------------------------------------------------------
    always_comb
    begin
        cur_time_next    = cur_time_reg;
        start_time_next  = start_time_reg;
        count_next       = count_reg;
        ch_next          = ch_reg;
        k_next           = k_reg;
        step_next        = step_reg;
        med_next         = med_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        noise_floor_next = noise_floor_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_next = UNKNOWN_FLOOR;
                    if (req_type == REQ_TICK)
                    begin
                        cur_time_next   = time_seconds;
                        start_time_next = restart_hit ? time_seconds : start_eff;
                        if (restart_hit)
                        begin
                            for (int c = 0; c < NUM_CHANNELS; c++)
                            begin
                                count_next[c] = '0;
                            end
                        end
                    end
                    else if (req_type == REQ_SAMPLE && ch_ok && time_known)
                    begin
                        count_next[ch_sel] = n_new;
                    end
                    if (go_select)
                    begin
                        ch_next   = ch_sel;
                        k_next    = n_sel >> 1;
                        step_next = BIT_IDX_W'(RSSI_W - 1);
                        med_next  = '0;
                    end
                end
            end
            ST_SELECT:
            begin
                if (bit_one)
                begin
                    k_next = k_reg - zeros;
                end
                med_next[step_reg] = bit_one;
                step_next          = step_reg - BIT_IDX_W'(1);
                if (step_reg == '0)
                begin
                    res_next = med_next;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    noise_floor_next = res_reg;
                end
            end
            default:
            begin
                res_next = UNKNOWN_FLOOR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_time_reg   <= '0;
            start_time_reg <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                count_reg[c] <= '0;
            end
            ch_reg         <= '0;
            k_reg          <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_time_reg   <= cur_time_next;
            start_time_reg <= start_time_next;
            count_reg      <= count_next;
            ch_reg         <= ch_next;
            k_reg          <= k_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        med_reg         <= med_next;
        res_reg         <= res_next;
        noise_floor_reg <= noise_floor_next;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The wanted rank always lies inside the surviving candidate set.
    a_rank_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SELECT) |-> (k_reg < CNT_W'($countones(cand_vec))))
        else $error("rank select lost its target reading");

    // A tick never starts a rank selection.
    a_tick_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req_type == REQ_TICK) |=> (state_reg == ST_DONE))
        else $error("tick beat did not go straight to result hand-off");

    // Channel 0 window occupancy never exceeds the window depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[0] <= CNT_W'(WINDOW_DEPTH)))
        else $error("window count exceeds depth");

    // A finished result is moved into the output register unchanged.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=>
        (out_valid && noise_floor == $past(res_reg)))
        else $error("result hand-off to output register failed");

endmodule
